>>> hdl/timer_keypad_control_unit_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer and keypad control unit
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TIMER_KEYPAD_CONTROL_UNIT_CORE_MACROS_SVH
`define TIMER_KEYPAD_CONTROL_UNIT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TKCU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TKCU_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TKCU_ASSERT(label, clk, rst, prop, msg)
`define TKCU_NEVER(label, clk, rst, expr, msg)
`endif
`endif

>>> hdl/tkcu_pkg.sv
// ----------------------------------------------------------------------------
// Timer and keypad control unit package
// Request and result types, register and action codes, interval reload.
// ----------------------------------------------------------------------------
package tkcu_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_KEY   = 2'd3
  } action_t;

  localparam logic [3:0] RegSdlr  = 4'd4;
  localparam logic [3:0] RegSdhr  = 4'd5;
  localparam logic [3:0] RegTlr   = 4'd6;
  localparam logic [3:0] RegThr   = 4'd7;
  localparam logic [3:0] RegTcr   = 4'd8;
  localparam logic [3:0] RegWcr   = 4'd9;
  localparam logic [3:0] RegScr   = 4'd10;
  localparam logic [3:0] RegCount = 4'd11;

  localparam logic [30:0] FracOne  = 31'd1000000000;
  localparam logic [30:0] FracFast = 31'd175781250;
  localparam logic [30:0] FracSlow = 31'd878906250;
  localparam logic [10:0] SpanFast = 11'd305;
  localparam logic [10:0] SpanSlow = 11'd1525;
  localparam logic [15:0] CountReset  = 16'hffff;
  localparam logic [7:0]  SerialReset = 8'h4c;
  localparam logic [15:0] KeysReset   = 16'h0002;

  typedef struct packed {
    action_t     action;
    logic [3:0]  reg_index;
    logic [7:0]  write_data;
    logic [3:0]  key_index;
    logic        key_pressed;
  } request_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
    logic       key_irq;
    logic       bus_error;
  } result_t;

  typedef struct packed {
    logic csel;
    logic zie;
    logic zst;
    logic enb;
  } timer_ctrl_t;

  typedef struct packed {
    logic [10:0] span;
    logic [29:0] frac;
  } interval_t;

  function automatic interval_t load_interval(input logic csel, input logic [29:0] frac);
    logic [30:0] sum;
    interval_t   iv;
    sum     = {1'b0, frac} + (csel ? FracFast : FracSlow);
    iv.span = csel ? SpanFast : SpanSlow;
    iv.frac = sum[29:0];
    if (sum > FracOne) begin
      iv.span = iv.span + 11'd1;
      iv.frac = 30'(sum - FracOne);
    end
    return iv;
  endfunction

endpackage

>>> hdl/tkcu_stream_if.sv
// ----------------------------------------------------------------------------
// Timer and keypad control unit stream channel
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface tkcu_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/timer_keypad_control_unit_core.sv
// ----------------------------------------------------------------------------
// Timer and keypad control unit core
// Eleven byte registers, a down-counting interval timer and a keypad latch.
// ----------------------------------------------------------------------------
// Each request (tick, register read, register write or key change) is
// applied to the register state at the edge that accepts it and
// its result is held in a single output register. Requests are accepted every
// cycle while that register is empty or being taken in the same cycle, so the
// sustained rate is one request per clock, set by the result register.
`include "timer_keypad_control_unit_core_macros.svh"

module timer_keypad_control_unit_core
  import tkcu_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  tkcu_stream_if.sink   request,
  tkcu_stream_if.source result
);

  logic [7:0]  comm_regs [4];
  logic [15:0] key_latch, key_latch_next;
  logic [15:0] count_shown, count_shown_next;
  logic [15:0] preset_value, preset_value_next;
  logic [15:0] reload_count, reload_count_next;
  logic [10:0] wait_usec, wait_usec_next;
  logic [29:0] frac_accum, frac_accum_next;
  timer_ctrl_t timer_ctrl, timer_ctrl_next;
  logic [7:0]  wait_ctrl, wait_ctrl_next;
  logic [7:0]  serial_ctrl, serial_ctrl_next;
  logic [15:0] keys_held, keys_held_next;
  result_t     out_data, out_next;
  logic        out_valid;

  request_t    req;
  logic        req_accept;
  logic        reg_ok;
  logic        load_csel;
  interval_t   iv;
  logic [10:0] wait_dec;
  logic [15:0] key_bit;
  logic [7:0]  rd_byte;

  assign req        = request.data;
  assign request.ready = !out_valid || result.ready;
  assign req_accept = request.valid && request.ready;
  assign reg_ok     = req.reg_index < RegCount;

  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign load_csel = (req.action == ACT_WRITE && req.reg_index == RegTcr) ?
                     req.write_data[4] : timer_ctrl.csel;
  assign iv        = load_interval(load_csel, frac_accum);
  assign wait_dec  = (wait_usec != '0) ? wait_usec - 11'd1 : '0;
  assign key_bit   = 16'd1 << req.key_index;

  always_comb begin
    unique case (req.reg_index)
      4'd0, 4'd1, 4'd2, 4'd3: rd_byte = comm_regs[req.reg_index[1:0]];
      RegSdlr: rd_byte = key_latch[7:0];
      RegSdhr: rd_byte = key_latch[15:8];
      RegTlr:  rd_byte = count_shown[7:0];
      RegThr:  rd_byte = count_shown[15:8];
      RegTcr:  rd_byte = {3'b000, timer_ctrl.csel, timer_ctrl.zie, 1'b0,
                          timer_ctrl.zst, timer_ctrl.enb};
      RegWcr:  rd_byte = wait_ctrl;
      default: rd_byte = serial_ctrl;
    endcase
  end

  always_comb begin
    key_latch_next    = key_latch;
    count_shown_next  = count_shown;
    preset_value_next = preset_value;
    reload_count_next = reload_count;
    wait_usec_next    = wait_usec;
    frac_accum_next   = frac_accum;
    timer_ctrl_next   = timer_ctrl;
    wait_ctrl_next    = wait_ctrl;
    serial_ctrl_next  = serial_ctrl;
    keys_held_next    = keys_held;
    out_next          = '0;
    unique case (req.action)
      ACT_TICK: begin
        if (timer_ctrl.enb) begin
          wait_usec_next = wait_dec;
          if (wait_dec == '0) begin
            count_shown_next = reload_count;
            wait_usec_next   = iv.span;
            frac_accum_next  = iv.frac;
            if (reload_count != '0) begin
              reload_count_next = reload_count - 16'd1;
            end else begin
              reload_count_next   = preset_value;
              timer_ctrl_next.zst = 1'b1;
              out_next.timer_irq  = timer_ctrl.zie;
            end
          end
        end
      end
      ACT_READ: begin
        out_next.bus_error = !reg_ok;
        if (reg_ok) out_next.read_data = rd_byte;
      end
      ACT_WRITE: begin
        out_next.bus_error = !reg_ok;
        if (reg_ok) begin
          unique case (req.reg_index)
            RegSdlr: key_latch_next[7:0]     = req.write_data;
            RegSdhr: key_latch_next[15:8]    = req.write_data;
            RegTlr:  preset_value_next[7:0]  = req.write_data;
            RegThr:  preset_value_next[15:8] = req.write_data;
            RegTcr: begin
              timer_ctrl_next.zie = req.write_data[3];
              timer_ctrl_next.csel = req.write_data[4];
              timer_ctrl_next.enb = req.write_data[0];
              timer_ctrl_next.zst = timer_ctrl.zst && !req.write_data[2];
              if (!timer_ctrl.enb && req.write_data[0]) begin
                wait_usec_next    = iv.span;
                frac_accum_next   = iv.frac;
                reload_count_next = preset_value;
              end
            end
            RegWcr:  wait_ctrl_next   = req.write_data;
            RegScr:  serial_ctrl_next = req.write_data;
            default: ;
          endcase
        end
      end
      default: begin
        keys_held_next = req.key_pressed ? (keys_held | key_bit) : (keys_held & ~key_bit);
        if (serial_ctrl[2]) begin
          out_next.key_irq    = req.key_pressed && !serial_ctrl[7] &&
                                !key_latch[req.key_index];
          key_latch_next      = keys_held_next;
          serial_ctrl_next[1] = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) comm_regs[i] <= '0;
      key_latch    <= '0;
      count_shown  <= CountReset;
      preset_value <= CountReset;
      reload_count <= '0;
      wait_usec    <= '0;
      frac_accum   <= '0;
      timer_ctrl   <= '0;
      wait_ctrl    <= '0;
      serial_ctrl  <= SerialReset;
      keys_held    <= KeysReset;
      out_valid    <= 1'b0;
    end else begin
      if (req_accept) begin
        if (req.action == ACT_WRITE && req.reg_index[3:2] == 2'b00) begin
          comm_regs[req.reg_index[1:0]] <= req.write_data;
        end
        key_latch    <= key_latch_next;
        count_shown  <= count_shown_next;
        preset_value <= preset_value_next;
        reload_count <= reload_count_next;
        wait_usec    <= wait_usec_next;
        frac_accum   <= frac_accum_next;
        timer_ctrl   <= timer_ctrl_next;
        wait_ctrl    <= wait_ctrl_next;
        serial_ctrl  <= serial_ctrl_next;
        keys_held    <= keys_held_next;
        out_valid    <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) out_data <= out_next;
  end

  `TKCU_NEVER(a_wait_range, clk, rst, wait_usec > SpanSlow + 11'd1, "wait interval out of range")
  `TKCU_NEVER(a_frac_range, clk, rst, {1'b0, frac_accum} > FracOne, "fraction above one")
  `TKCU_ASSERT(a_idle_count, clk, rst, !timer_ctrl.enb |=> $stable(count_shown), "count moved while disabled")
  `TKCU_ASSERT(a_irq_zero, clk, rst, (req_accept && out_next.timer_irq) |=> timer_ctrl.zst, "timer interrupt without zero status")

endmodule
